FILE: sv/dms_pkg.sv
// shared types, constants and helpers for the doorbell melody sequencer
package dms_pkg;

  localparam int MAX_NOTES = 256;
  localparam int NOTE_AW   = $clog2(MAX_NOTES);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_SONG_LENGTH = 1'b0;  // word index of song_length
  localparam int SONG_LEN_W = 9;
  localparam logic [SONG_LEN_W-1:0] SONG_LEN_RESET = 9'd1;

  // item codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // tone and timing
  localparam logic [15:0] SILENT_PITCH   = 16'd100;
  localparam int          PITCH_DIV      = 100;
  localparam int          TICKS_PER_UNIT = 100;
  localparam int          TIME_MAX       = 65535;
  localparam int          VOL_SHIFT      = 6;

  // stop button in screen coordinates, bounds included
  localparam int SCR_W     = 240;
  localparam int SCR_H     = 320;
  localparam int RAW_MAX   = 255;
  localparam int BOX_X_LO  = 60;
  localparam int BOX_X_HI  = 220;
  localparam int BOX_Y_LO  = 180;
  localparam int BOX_Y_HI  = 220;
  // same box in raw touch units, so no scaling is needed at run time
  localparam logic [7:0] RAW_X_LO = 8'((BOX_X_LO * RAW_MAX + SCR_W - 1) / SCR_W);
  localparam logic [7:0] RAW_X_HI = 8'(((BOX_X_HI + 1) * RAW_MAX - 1) / SCR_W);
  localparam logic [7:0] RAW_Y_LO = 8'((BOX_Y_LO * RAW_MAX + SCR_H - 1) / SCR_H);
  localparam logic [7:0] RAW_Y_HI = 8'(((BOX_Y_HI + 1) * RAW_MAX - 1) / SCR_H);
  localparam logic [11:0] TOUCH_MIN_PRESSURE = 12'd1;

  typedef struct packed {
    logic        operation;
    logic        button_level;
    logic [7:0]  touch_x;
    logic [7:0]  touch_y;
    logic [11:0] touch_pressure;
    logic [7:0]  entry_address;
    logic [15:0] entry_pitch;
    logic [9:0]  entry_volume;
    logic [9:0]  entry_duration;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dac_value;
    logic        is_playing;
    logic [7:0]  current_note;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pitch;
    logic [9:0]  volume;
    logic [9:0]  duration;
  } note_entry_t;

  // note length in ticks, saturated to the time counter range
  function automatic logic [15:0] note_time(input logic [9:0] dur);
    logic [16:0] t;
    t = 17'(dur) * 17'(TICKS_PER_UNIT);
    return (t > 17'(TIME_MAX)) ? 16'(TIME_MAX) : t[15:0];
  endfunction

endpackage

FILE: sv/doorbell_melody_sequencer_top.sv
// doorbell melody sequencer: button/touch play control and square-wave note player
// output: an accepted input beat's result beat is in the output register the next cycle
// throughput: one item per cycle unless out_ready stalls; the table is read each cycle
//   at the next note position and the one after it, so a tick never waits on the table
// reset: play off, counters and converter zero, song_length 1; the note table has
//   no clearing pass and entries are undefined until loaded
module doorbell_melody_sequencer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dms_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dms_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dms_pkg::CFG_AW-1:0] paddr,
  input  logic [dms_pkg::CFG_DW-1:0] pwdata,
  output logic [dms_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import dms_pkg::*;

  // handshake
  logic in_fire;
  logic tick_fire;
  logic load_fire;

  // player state
  logic                  playing_r,  playing_nxt;
  logic                  last_btn_r, last_btn_nxt;
  logic [NOTE_AW-1:0]    pos_r,      pos_nxt;
  logic [15:0]           ticks_r,    ticks_nxt;
  logic [15:0]           hp_cnt_r,   hp_cnt_nxt;
  logic                  wave_r,     wave_nxt;
  logic [15:0]           dac_r,      dac_nxt;
  logic [SONG_LEN_W-1:0] song_len_r;
  logic [9:0]            dur0_r;     // copy of entry 0 duration, reloaded on song end

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  // table access
  logic               wr_en;
  logic [NOTE_AW-1:0] wr_addr;
  note_entry_t        wr_data;
  note_entry_t        cur_note;   // entry at pos_r
  note_entry_t        next_note;  // entry at pos_r + 1

  // step intermediates
  logic              btn_fall;
  logic              touch_hit;
  logic              play_mid;
  logic [15:0]       cnt_inc;
  logic [22:0]       toggle_lim;
  logic              toggle;
  logic              note_done;
  logic [NOTE_AW:0]  pos_inc;
  logic              song_end;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (in_item.operation == OP_TICK);
  assign load_fire = in_fire && (in_item.operation == OP_LOAD);

  // ---------------------------------------------------------------------------
  // configuration port: one register; pready is tied high, so the port never inserts wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_len_r <= SONG_LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SONG_LENGTH)) begin
      song_len_r <= pwdata[SONG_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SONG_LENGTH) begin
      prdata = CFG_DW'(song_len_r);
    end
  end

  // ---------------------------------------------------------------------------
  // note table: loads write it, the player reads ahead at the next positions
  // ---------------------------------------------------------------------------
  assign wr_en   = load_fire && (16'(in_item.entry_address) < 16'(MAX_NOTES));
  assign wr_addr = NOTE_AW'(in_item.entry_address);
  assign wr_data = '{pitch:    in_item.entry_pitch,
                     volume:   in_item.entry_volume,
                     duration: in_item.entry_duration};

  dms_note_ram u_note_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (pos_nxt),
    .rd_b_addr (pos_nxt + NOTE_AW'(1)),
    .rd_a_data (cur_note),
    .rd_b_data (next_note)
  );

  // entry 0 is needed on the song-end reload while the read ports look ahead
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      dur0_r <= in_item.entry_duration;
    end
  end

  // ---------------------------------------------------------------------------
  // tick step
  // ---------------------------------------------------------------------------
  assign btn_fall  = last_btn_r && !in_item.button_level;
  // scaled point in the stop box, compared in raw touch units
  assign touch_hit = (in_item.touch_pressure > TOUCH_MIN_PRESSURE) &&
                     (in_item.touch_x >= RAW_X_LO) && (in_item.touch_x <= RAW_X_HI) &&
                     (in_item.touch_y >= RAW_Y_LO) && (in_item.touch_y <= RAW_Y_HI);
  assign play_mid  = (playing_r ^ btn_fall) && !touch_hit;

  // count >= pitch/100 is the same as pitch < 100*(count+1)
  assign cnt_inc    = hp_cnt_r + 16'd1;
  assign toggle_lim = (23'(cnt_inc) + 23'd1) * 23'(PITCH_DIV);
  assign toggle     = 23'(cur_note.pitch) < toggle_lim;

  // remaining time reaches zero on this tick
  assign note_done = ticks_r <= 16'd1;
  assign pos_inc   = {1'b0, pos_r} + (NOTE_AW+1)'(1);
  assign song_end  = (16'(pos_inc) >= 16'(song_len_r)) || (16'(pos_inc) >= 16'(MAX_NOTES));

  always_comb begin
    playing_nxt  = playing_r;
    last_btn_nxt = last_btn_r;
    pos_nxt      = pos_r;
    ticks_nxt    = ticks_r;
    hp_cnt_nxt   = hp_cnt_r;
    wave_nxt     = wave_r;
    dac_nxt      = dac_r;
    if (tick_fire) begin
      last_btn_nxt = in_item.button_level;
      playing_nxt  = play_mid;
      if (play_mid) begin
        // square wave on the current note
        if (cur_note.pitch == SILENT_PITCH) begin
          dac_nxt = '0;
        end else if (toggle) begin
          wave_nxt   = !wave_r;
          dac_nxt    = !wave_r ? 16'({cur_note.volume, VOL_SHIFT'(0)}) : 16'd0;
          hp_cnt_nxt = '0;
        end else begin
          hp_cnt_nxt = cnt_inc;
        end
        // note timing
        if (note_done) begin
          if (song_end) begin
            pos_nxt     = '0;
            playing_nxt = 1'b0;
            ticks_nxt   = note_time(dur0_r);
          end else begin
            pos_nxt   = pos_inc[NOTE_AW-1:0];
            ticks_nxt = note_time(next_note.duration);
          end
        end else begin
          ticks_nxt = ticks_r - 16'd1;
        end
      end else begin
        // idle: converter and counters clear, wave level stays
        dac_nxt    = '0;
        pos_nxt    = '0;
        ticks_nxt  = '0;
        hp_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r  <= 1'b0;
      last_btn_r <= 1'b1;
      pos_r      <= '0;
      ticks_r    <= '0;
      hp_cnt_r   <= '0;
      wave_r     <= 1'b0;
      dac_r      <= '0;
    end else begin
      playing_r  <= playing_nxt;
      last_btn_r <= last_btn_nxt;
      pos_r      <= pos_nxt;
      ticks_r    <= ticks_nxt;
      hp_cnt_r   <= hp_cnt_nxt;
      wave_r     <= wave_nxt;
      dac_r      <= dac_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result beat: state after the item, held until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= '{dac_value:    dac_nxt,
                      is_playing:   playing_nxt,
                      current_note: 8'(pos_nxt)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a load beat leaves the play state untouched in its result
  a_load_keeps_play: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> (out_item_r.is_playing == $past(playing_r)) &&
                  (out_item_r.current_note == 8'($past(pos_r))))
    else $error("load beat changed play state");

  // the position is parked at the first note whenever play is off
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !playing_r |-> (pos_r == '0))
    else $error("note position nonzero while stopped");

  // an idle tick with no button press clears converter and time counter
  a_idle_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_fire && !playing_r && !btn_fall) |=> (dac_r == '0) && (ticks_r == '0) &&
                                               !playing_r)
    else $error("idle tick left converter or counter set");

endmodule

FILE: sv/dms_note_ram.sv
// note table: one write port, two registered read ports with write forwarding
module dms_note_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [dms_pkg::NOTE_AW-1:0] wr_addr,
  input  dms_pkg::note_entry_t        wr_data,
  input  logic [dms_pkg::NOTE_AW-1:0] rd_a_addr,
  input  logic [dms_pkg::NOTE_AW-1:0] rd_b_addr,
  output dms_pkg::note_entry_t        rd_a_data,
  output dms_pkg::note_entry_t        rd_b_data
);
  import dms_pkg::*;

  note_entry_t mem [MAX_NOTES];
  note_entry_t q_a_r;
  note_entry_t q_b_r;
  note_entry_t wdata_r;
  logic        byp_a_r;
  logic        byp_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a_r   <= mem[rd_a_addr];
    q_b_r   <= mem[rd_b_addr];
    wdata_r <= wr_data;
  end

  // same-cycle write to a read address returns the new entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      byp_a_r <= wr_en && (wr_addr == rd_a_addr);
      byp_b_r <= wr_en && (wr_addr == rd_b_addr);
    end
  end

  assign rd_a_data = byp_a_r ? wdata_r : q_a_r;
  assign rd_b_data = byp_b_r ? wdata_r : q_b_r;

endmodule

FILE: sim/doorbell_melody_sequencer_top_tb.sv
// self-checking testbench for the doorbell melody sequencer with a predicting scoreboard
module doorbell_melody_sequencer_top_tb;
  import dms_pkg::*;

  localparam int STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int HEAD_NOTES  = 16;    // table region that short songs play from

  // tone player model plus the queue of outputs it predicts
  class melody_model;
    note_entry_t notes[MAX_NOTES];
    logic [SONG_LEN_W-1:0] song_len;
    bit          playing;
    bit          last_btn;
    logic [7:0]  pos;
    int          ticks_left;
    logic [15:0] half_cnt;
    bit          wave_hi;
    logic [15:0] dac;
    out_item_t   due_outputs[$];
    int          errors;

    function new();
      song_len   = SONG_LEN_RESET;
      playing    = 1'b0;
      last_btn   = 1'b1;
      pos        = '0;
      ticks_left = 0;
      half_cnt   = '0;
      wave_hi    = 1'b0;
      dac        = '0;
      errors     = 0;
    endfunction

    // apply one accepted input beat and queue the output it produces
    function void play_beat(in_item_t it);
      out_item_t e;
      int px, py, nxt;
      if (it.operation == OP_LOAD) begin
        notes[it.entry_address] = {it.entry_pitch, it.entry_volume, it.entry_duration};
      end else begin
        // falling edge of the button toggles play
        if (last_btn && !it.button_level) playing = !playing;
        last_btn = it.button_level;
        // touch inside the stop button, scaled to screen units
        px = int'(it.touch_x) * SCR_W / RAW_MAX;
        py = int'(it.touch_y) * SCR_H / RAW_MAX;
        if (it.touch_pressure > 12'd1 && px >= BOX_X_LO && px <= BOX_X_HI &&
            py >= BOX_Y_LO && py <= BOX_Y_HI)
          playing = 1'b0;
        if (playing) begin
          if (notes[pos].pitch == SILENT_PITCH) begin
            dac = '0;
          end else begin
            half_cnt = half_cnt + 16'd1;
            if (half_cnt >= notes[pos].pitch / 16'(PITCH_DIV)) begin
              wave_hi  = !wave_hi;
              dac      = wave_hi ? {notes[pos].volume, 6'b0} : 16'd0;
              half_cnt = '0;
            end
          end
          ticks_left = ticks_left - 1;
          if (ticks_left <= 0) begin
            nxt = int'(pos) + 1;
            if (nxt >= int'(song_len) || nxt >= MAX_NOTES) begin
              nxt     = 0;
              playing = 1'b0;
            end
            pos        = 8'(nxt);
            ticks_left = int'(notes[pos].duration) * TICKS_PER_UNIT;
            if (ticks_left > TIME_MAX) ticks_left = TIME_MAX;
          end
        end else begin
          dac        = '0;
          pos        = '0;
          ticks_left = 0;
          half_cnt   = '0;
        end
      end
      e.dac_value    = dac;
      e.is_playing   = playing;
      e.current_note = pos;
      due_outputs.push_back(e);
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (due_outputs.size() == 0) begin
        $error("output beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = due_outputs.pop_front();
      if (got.dac_value !== want.dac_value) begin
        $error("dac_value: expected %0d, got %0d", want.dac_value, got.dac_value);
        errors++;
      end
      if (got.is_playing !== want.is_playing) begin
        $error("is_playing: expected %0d, got %0d", want.is_playing, got.is_playing);
        errors++;
      end
      if (got.current_note !== want.current_note) begin
        $error("current_note: expected %0d, got %0d", want.current_note, got.current_note);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  melody_model model = new();
  int  send_idle;    // percent of cycles the sender holds back
  int  recv_idle;    // percent of cycles the receiver stalls
  bit  quiet_mode;   // few interruptions, so long songs run to the end
  bit  btn_level;
  int  stuck_cycles;

  doorbell_melody_sequencer_top i_dut (.*);

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) model.play_beat(in_item);
      if (out_valid && out_ready) model.check_output(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  function automatic in_item_t rand_junk();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [15:0] rand_pitch();
    case ($urandom_range(9))
      0, 1:    return SILENT_PITCH;
      2:       return 16'($urandom);
      3, 4:    return 16'($urandom_range(5000, 801));
      default: return 16'($urandom_range(800));
    endcase
  endfunction

  // random beat: mostly ticks with a slowly changing button, some table loads
  function automatic in_item_t rand_beat();
    in_item_t it;
    int flip_odds;
    it = rand_junk();
    if ($urandom_range(9) == 0) begin
      it.operation     = OP_LOAD;
      it.entry_address = ($urandom_range(3) != 0) ? 8'($urandom_range(HEAD_NOTES - 1))
                                                  : 8'($urandom);
      it.entry_pitch   = rand_pitch();
      // long notes only in the head region and outside quiet runs
      if (quiet_mode || it.entry_address >= HEAD_NOTES) begin
        it.entry_duration = '0;
      end else begin
        case ($urandom_range(9))
          0:       ;  // keep the full random length
          1, 2, 3: it.entry_duration = 10'($urandom_range(2, 1));
          default: it.entry_duration = '0;
        endcase
      end
    end else begin
      it.operation = OP_TICK;
      if (quiet_mode) flip_odds = model.playing ? 1000 : 2;
      else flip_odds = 12;
      if ($urandom_range(flip_odds - 1) == 0) btn_level = !btn_level;
      it.button_level = btn_level;
      if (quiet_mode || $urandom_range(9) < 6) it.touch_pressure = 12'($urandom_range(1));
      // lean toward the stop button rows
      if ($urandom_range(3) == 0) it.touch_y = 8'($urandom_range(180, 140));
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic tick(input logic b, input logic [7:0] x, input logic [7:0] y,
                      input logic [11:0] p);
    in_item_t it;
    it                = rand_junk();
    it.operation      = OP_TICK;
    it.button_level   = b;
    it.touch_x        = x;
    it.touch_y        = y;
    it.touch_pressure = p;
    btn_level         = b;
    send_beat(it);
  endtask

  task automatic load(input logic [7:0] a, input logic [15:0] p, input logic [9:0] v,
                      input logic [9:0] d);
    in_item_t it;
    it                = rand_junk();
    it.operation      = OP_LOAD;
    it.entry_address  = a;
    it.entry_pitch    = p;
    it.entry_volume   = v;
    it.entry_duration = d;
    send_beat(it);
  endtask

  // stop sending and let every predicted output arrive
  task automatic drain();
    in_valid <= 1'b0;
    while (model.due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // new song length while idle, head reloads for quiet runs, then a run of random beats
  task automatic run_segment(input logic [SONG_LEN_W-1:0] len, input bit quiet,
                             input int count);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_SONG_LENGTH, 2'b00};
    pwdata  <= CFG_DW'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.song_len = len;
    quiet_mode     = quiet;
    // short notes at the head so a full song fits in the run
    if (quiet)
      for (int a = 0; a < HEAD_NOTES; a++) load(8'(a), rand_pitch(), 10'($urandom), 10'd0);
    repeat (count) send_beat(rand_beat());
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_idle    = 16;
    recv_idle    = 55;
    quiet_mode   = 1'b0;
    btn_level    = 1'b1;
    stuck_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every table entry written before any note can be played
    for (int a = 0; a < MAX_NOTES; a++) load(8'(a), rand_pitch(), 10'($urandom), 10'd0);

    run_segment(9'd4, 1'b0, 0);
    load(8'd0, 16'd0, 10'h3FF, 10'd0);        // pitch below 100 toggles every tick
    load(8'd1, SILENT_PITCH, 10'h3FF, 10'd0);
    load(8'd2, 16'hFFFF, 10'd0, 10'd0);
    load(8'd3, 16'd300, 10'h200, 10'h3FF);    // note time saturates
    load(8'd255, 16'd250, 10'h155, 10'd0);    // top of the table
    tick(1'b1, 8'd0, 8'd0, 12'd0);
    tick(1'b0, 8'd0, 8'd0, 12'd0);            // press starts, first note one tick
    tick(1'b0, 8'hFF, 8'hFF, 12'hFFF);        // held, touch far outside
    tick(1'b0, 8'd200, 8'd150, 12'd1);        // inside the box but too light
    tick(1'b0, 8'd64, 8'd144, 12'd2);         // near corner of the box stops
    tick(1'b1, 8'd63, 8'd150, 12'hFFF);
    tick(1'b0, 8'd235, 8'd150, 12'hFFF);      // starts, just right of the box
    tick(1'b0, 8'd100, 8'd143, 12'hFFF);      // just above
    tick(1'b0, 8'd100, 8'd177, 12'hFFF);      // just below
    tick(1'b0, 8'd234, 8'd176, 12'hFFF);      // far corner of the box stops
    tick(1'b1, 8'd0, 8'd0, 12'd0);
    tick(1'b0, 8'd150, 8'd160, 12'd3);        // press and touch on one tick
    tick(1'b1, 8'd0, 8'd0, 12'd0);
    tick(1'b0, 8'd0, 8'd0, 12'd0);
    repeat (3) tick(1'b0, 8'd0, 8'd0, 12'd0); // runs into the long note
    load(8'd3, 16'd300, 10'h200, 10'd0);      // rewrite the note being played
    tick(1'b1, 8'd0, 8'd0, 12'd0);
    tick(1'b0, 8'd0, 8'd0, 12'd0);            // button stops play
    repeat (100) send_beat(rand_beat());

    run_segment(9'd0, 1'b0, 120);             // stops at the first note change
    run_segment(9'd1, 1'b0, 120);

    send_idle = 55;
    recv_idle = 16;
    run_segment(9'd256, 1'b1, 400);           // whole table
    run_segment(9'd7, 1'b0, 100);

    send_idle = 0;
    recv_idle = 0;
    run_segment(9'd300, 1'b1, 400);           // longer than the table
    run_segment(9'd511, 1'b0, 150);
    run_segment(SONG_LEN_W'($urandom_range(20, 2)), 1'b0, 100);

    drain();
    if (model.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: doorbell_melody_sequencer_top.f
sv/dms_pkg.sv
sv/dms_note_ram.sv
sv/doorbell_melody_sequencer_top.sv
sim/doorbell_melody_sequencer_top_tb.sv
